### sv/mesh_xy_route_with_broadcast_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mesh XY route core
// Both macros sample on clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MESH_XY_ROUTE_WITH_BROADCAST_CORE_ASSERT_SVH
`define MESH_XY_ROUTE_WITH_BROADCAST_CORE_ASSERT_SVH

// same-cycle implication
`define MXYR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mxyr assertion failed");

// next-cycle implication
`define MXYR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mxyr assertion failed");

`endif

### sv/mxyr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxyr_pkg
// Shared widths, codes and item types of the mesh XY route core.
// ----------------------------------------------------------------------------
package mxyr_pkg;

   localparam int TILE_W           = 12;
   localparam int DIM_W            = 7;
   localparam int PORT_W           = 3;
   localparam int NUM_PORTS        = 5;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 7;
   localparam int MESH_DIM_MAX_DEF = 64;

   localparam logic [DIM_W-1:0] MESH_WIDTH_RST  = 7'd4;
   localparam logic [DIM_W-1:0] MESH_HEIGHT_RST = 7'd4;

   typedef enum logic [PORT_W-1:0] {
      PORT_UP    = 3'd0,
      PORT_DOWN  = 3'd1,
      PORT_LEFT  = 3'd2,
      PORT_RIGHT = 3'd3,
      PORT_SELF  = 3'd4
   } port_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MESH_WIDTH  = 1'b0,
      REG_MESH_HEIGHT = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic              mode;
      logic [TILE_W-1:0] current_tile;
      logic [TILE_W-1:0] sender_tile;
      logic [TILE_W-1:0] receiver_tile;
      logic              broadcast;
   } req_item_type;

   typedef struct packed {
      logic [TILE_W-1:0] next_tile;
      logic [PORT_W-1:0] hop_port;
      logic              deliver_local;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [DIM_W-1:0]  x;
      logic [TILE_W-1:0] y;
   } xy_type;

   typedef struct packed {
      req_item_type item;
      xy_type       cur;
      xy_type       snd;
      xy_type       rcv;
   } route_coord_type;

   typedef struct packed {
      logic [NUM_PORTS-1:0] mask;
      logic                 self_local;
      logic [TILE_W-1:0]    cur;
   } route_dec_type;

endpackage

### sv/mxyr_div_pipe.sv
`timescale 1ns / 1ps
`include "mesh_xy_route_with_broadcast_core_assert.svh"
// ----------------------------------------------------------------------------
// mxyr_div_pipe
// Pipelined restoring divider: splits current, sender and receiver tile ids
// into column (remainder) and row (quotient), three quotient bits per stage.
// ----------------------------------------------------------------------------
module mxyr_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  mxyr_pkg::req_item_type        in_item,
   input  logic [mxyr_pkg::DIM_W-1:0]    mesh_w,
   output logic                          out_valid,
   input  logic                          out_ready,
   output mxyr_pkg::route_coord_type     out_coord
);
   import mxyr_pkg::*;

   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = TILE_W / DIV_BITS;

   typedef struct packed {
      logic [DIM_W-1:0]  rem;
      logic [TILE_W-1:0] quo;
   } div_state_type;

   typedef struct packed {
      req_item_type  item;
      div_state_type cur;
      div_state_type snd;
      div_state_type rcv;
   } stage_type;

   function automatic div_state_type div_step(input div_state_type d,
                                              input logic [DIV_BITS-1:0] bits,
                                              input logic [DIM_W-1:0] w);
      div_state_type r;
      logic [DIM_W:0] part;
      r = d;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         part = {r.rem, bits[i]};
         if (part >= {1'b0, w}) begin
            part  = part - {1'b0, w};
            r.quo = {r.quo[TILE_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[TILE_W-2:0], 1'b0};
         end
         r.rem = part[DIM_W-1:0];
      end
      return r;
   endfunction

   stage_type               st_ff [DIV_STAGES];
   stage_type               st_in [DIV_STAGES];
   stage_type               src   [DIV_STAGES];
   logic [DIV_STAGES-1:0]   v_ff;
   logic [DIV_STAGES-1:0]   src_v;
   logic [DIV_STAGES:0]     rdy;

   assign src[0].item = in_item;
   assign src[0].cur  = '0;
   assign src[0].snd  = '0;
   assign src[0].rcv  = '0;
   assign src_v[0]    = in_valid;
   assign rdy[DIV_STAGES] = out_ready;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int MSB = TILE_W - 1 - s * DIV_BITS;

      if (s > 0) begin : g_link
         assign src[s]   = st_ff[s-1];
         assign src_v[s] = v_ff[s-1];
      end

      assign rdy[s] = !v_ff[s] || rdy[s+1];

      always_comb begin
         st_in[s].item = src[s].item;
         st_in[s].cur  = div_step(src[s].cur, src[s].item.current_tile[MSB -: DIV_BITS],
                                  mesh_w);
         st_in[s].snd  = div_step(src[s].snd, src[s].item.sender_tile[MSB -: DIV_BITS],
                                  mesh_w);
         st_in[s].rcv  = div_step(src[s].rcv, src[s].item.receiver_tile[MSB -: DIV_BITS],
                                  mesh_w);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= src_v[s];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && src_v[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DIV_STAGES-1];

   always_comb begin
      out_coord.item  = st_ff[DIV_STAGES-1].item;
      out_coord.cur.x = st_ff[DIV_STAGES-1].cur.rem;
      out_coord.cur.y = st_ff[DIV_STAGES-1].cur.quo;
      out_coord.snd.x = st_ff[DIV_STAGES-1].snd.rem;
      out_coord.snd.y = st_ff[DIV_STAGES-1].snd.quo;
      out_coord.rcv.x = st_ff[DIV_STAGES-1].rcv.rem;
      out_coord.rcv.y = st_ff[DIV_STAGES-1].rcv.quo;
   end

   `MXYR_ASSERT_NEXT(a_div_out_hold, out_valid && !out_ready,
      out_valid && $stable(out_coord))
   `MXYR_ASSERT_NEXT(a_div_enter, in_valid && in_ready, v_ff[0])
   `MXYR_ASSERT_NEXT(a_div_first_hold, v_ff[0] && !rdy[1], v_ff[0] && $stable(st_ff[0]))

endmodule

### sv/mxyr_fanout.sv
`timescale 1ns / 1ps
`include "mesh_xy_route_with_broadcast_core_assert.svh"
// ----------------------------------------------------------------------------
// mxyr_fanout
// Serialize the hops of one decision in the order up, down, right, left,
// self, into the output register, one per cycle unless rsp_ready stalls.
// ----------------------------------------------------------------------------
module mxyr_fanout (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  mxyr_pkg::route_dec_type      in_dec,
   input  logic [mxyr_pkg::DIM_W-1:0]   mesh_w,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mxyr_pkg::rsp_item_type       rsp_item
);
   import mxyr_pkg::*;

   logic [NUM_PORTS-1:0] pend_ff;
   logic [TILE_W-1:0]    cur_ff;
   logic                 local_ff;
   logic                 busy_ff;
   rsp_item_type         out_ff;
   logic                 out_v_ff;

   port_type             sel_port;
   logic [NUM_PORTS-1:0] rest;
   logic                 is_last;
   logic                 out_load;
   logic                 in_accept;
   logic [TILE_W-1:0]    hop_tile;
   rsp_item_type         emit;

   always_comb begin
      if (pend_ff[PORT_UP]) begin
         sel_port = PORT_UP;
      end else if (pend_ff[PORT_DOWN]) begin
         sel_port = PORT_DOWN;
      end else if (pend_ff[PORT_RIGHT]) begin
         sel_port = PORT_RIGHT;
      end else if (pend_ff[PORT_LEFT]) begin
         sel_port = PORT_LEFT;
      end else begin
         sel_port = PORT_SELF;
      end
   end

   always_comb begin
      case (sel_port)
         PORT_UP:    hop_tile = cur_ff + TILE_W'(mesh_w);
         PORT_DOWN:  hop_tile = cur_ff - TILE_W'(mesh_w);
         PORT_LEFT:  hop_tile = cur_ff - TILE_W'(1);
         PORT_RIGHT: hop_tile = cur_ff + TILE_W'(1);
         default:    hop_tile = cur_ff;
      endcase
   end

   assign rest      = pend_ff & ~(NUM_PORTS'(1) << sel_port);
   assign is_last   = (rest == '0);
   assign out_load  = busy_ff && (!out_v_ff || rsp_ready);
   assign in_ready  = !busy_ff || (out_load && is_last);
   assign in_accept = in_valid && in_ready;

   always_comb begin
      emit.next_tile     = hop_tile;
      emit.hop_port      = PORT_W'(sel_port);
      emit.deliver_local = (sel_port == PORT_SELF) && local_ff;
      emit.last          = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (in_accept) begin
            busy_ff <= 1'b1;
         end else if (out_load && is_last) begin
            busy_ff <= 1'b0;
         end
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         pend_ff  <= in_dec.mask;
         cur_ff   <= in_dec.cur;
         local_ff <= in_dec.self_local;
      end else if (out_load) begin
         pend_ff <= rest;
      end
      if (out_load) begin
         out_ff <= emit;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

   `MXYR_ASSERT_NOW(a_fan_busy_pend, busy_ff, pend_ff != '0)
   `MXYR_ASSERT_NOW(a_fan_self_last,
      rsp_valid && rsp_item.hop_port == PORT_W'(PORT_SELF), rsp_item.last)
   `MXYR_ASSERT_NEXT(a_fan_drain, out_load && is_last && !in_accept, !busy_ff)

endmodule

### sv/mesh_xy_route_with_broadcast_core.sv
`timescale 1ns / 1ps
`include "mesh_xy_route_with_broadcast_core_assert.svh"
// ----------------------------------------------------------------------------
// mesh_xy_route_with_broadcast_core
// Route computation for one router of a 2D mesh with XY routing and a
// broadcast tree. An item can enter every cycle while req_ready is high;
// injection and unicast items give one result each and flow at one item per
// cycle while rsp_ready does not stall. A broadcast gives one to five results
// (up, down, right, left, self, off-mesh neighbors dropped) and holds the
// fan-out stage until its last result enters the output register; this sets
// the broadcast rate. An item passes four divider stages (three quotient bits
// each) that split tile ids into column and row, a decision stage, a fan-out
// stage and the output register. Width and height clamp to 1..MAX_MESH_DIM.
// ----------------------------------------------------------------------------
module mesh_xy_route_with_broadcast_core #(
   parameter int MAX_MESH_DIM = mxyr_pkg::MESH_DIM_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mxyr_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mxyr_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_write_en,
   input  logic [mxyr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mxyr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mxyr_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > MAX_MESH_DIM) begin
         return DIM_W'(MAX_MESH_DIM);
      end else begin
         return v;
      end
   endfunction

   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [DIM_W-1:0]     mesh_w;
   logic [DIM_W-1:0]     mesh_h;

   logic                 div_valid;
   logic                 div_ready;
   route_coord_type      div_coord;

   route_dec_type        dec_ff;
   route_dec_type        dec_in;
   logic                 dec_v_ff;
   logic                 dec_rdy;
   logic                 fan_ready;

   logic                 up_ok;
   logic                 down_ok;
   logic                 right_ok;
   logic                 left_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MESH_WIDTH_RST;
         height_ff <= MESH_HEIGHT_RST;
      end else if (csr_write_en) begin
         case (reg_idx_type'(csr_index))
            REG_MESH_WIDTH:  width_ff  <= csr_data;
            REG_MESH_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign mesh_w = clamp_dim(width_ff);
   assign mesh_h = clamp_dim(height_ff);

   mxyr_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .mesh_w    (mesh_w),
      .out_valid (div_valid),
      .out_ready (dec_rdy),
      .out_coord (div_coord)
   );

   always_comb begin
      up_ok    = (13'(div_coord.cur.y) + 13'd1) < 13'(mesh_h);
      down_ok  = (div_coord.cur.y != '0)
              && ((13'(div_coord.cur.y) - 13'd1) < 13'(mesh_h));
      right_ok = ((8'(div_coord.cur.x) + 8'd1) < 8'(mesh_w))
              && (13'(div_coord.cur.y) < 13'(mesh_h));
      left_ok  = (div_coord.cur.x != '0) && (13'(div_coord.cur.y) < 13'(mesh_h));

      dec_in.cur        = div_coord.item.current_tile;
      dec_in.mask       = '0;
      dec_in.self_local = 1'b1;
      if (!div_coord.item.mode) begin
         dec_in.mask[PORT_SELF] = 1'b1;
         dec_in.self_local      = 1'b0;
      end else if (div_coord.item.broadcast) begin
         dec_in.mask[PORT_UP]    = (div_coord.cur.y >= div_coord.snd.y) && up_ok;
         dec_in.mask[PORT_DOWN]  = (div_coord.cur.y <= div_coord.snd.y) && down_ok;
         dec_in.mask[PORT_RIGHT] = (div_coord.cur.y == div_coord.snd.y)
                                && (div_coord.cur.x >= div_coord.snd.x) && right_ok;
         dec_in.mask[PORT_LEFT]  = (div_coord.cur.y == div_coord.snd.y)
                                && (div_coord.cur.x <= div_coord.snd.x) && left_ok;
         dec_in.mask[PORT_SELF]  = 1'b1;
      end else if (div_coord.cur.x > div_coord.rcv.x) begin
         dec_in.mask[PORT_LEFT] = 1'b1;
      end else if (div_coord.cur.x < div_coord.rcv.x) begin
         dec_in.mask[PORT_RIGHT] = 1'b1;
      end else if (div_coord.cur.y > div_coord.rcv.y) begin
         dec_in.mask[PORT_DOWN] = 1'b1;
      end else if (div_coord.cur.y < div_coord.rcv.y) begin
         dec_in.mask[PORT_UP] = 1'b1;
      end else begin
         dec_in.mask[PORT_SELF] = 1'b1;
      end
   end

   assign dec_rdy = !dec_v_ff || fan_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_v_ff <= 1'b0;
      end else if (dec_rdy) begin
         dec_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_rdy && div_valid) begin
         dec_ff <= dec_in;
      end
   end

   mxyr_fanout u_fanout (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_v_ff),
      .in_ready  (fan_ready),
      .in_dec    (dec_ff),
      .mesh_w    (mesh_w),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `MXYR_ASSERT_NOW(a_dec_mask_set, dec_v_ff, dec_ff.mask != '0)
   `MXYR_ASSERT_NOW(a_dec_inject_self, dec_v_ff && !dec_ff.self_local,
      dec_ff.mask == (NUM_PORTS'(1) << PORT_SELF))
   `MXYR_ASSERT_NEXT(a_csr_width, csr_write_en && csr_index == REG_MESH_WIDTH,
      width_ff == $past(csr_data))

endmodule
